[design/cba_pkg.sv]
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types, codes and constants of the compacting block allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

	// default sizing of the block table and of the heap
	localparam int MAX_BLOCKS_DEF = 16;
	localparam int HEAP_BYTES_DEF = 65536;

	// fixed field widths
	localparam int ADDR_W   = 32;
	localparam int OFF_W    = 17;
	localparam int STATUS_W = 3;
	localparam int HEAP_W   = 25;
	localparam int CFG_W    = 32;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 120;

	// reset value of the heap limit register
	localparam logic [OFF_W-1:0] HEAP_LIMIT_RST = 17'h10000;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_HEAP_BASE  = 1'b0,
		CFG_HEAP_LIMIT = 1'b1
	} cfg_index_t;

	// request codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_ZERO      = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	// which result the output register loads
	typedef enum logic [1:0] {
		RES_ALLOC,
		RES_NOT_FOUND,
		RES_MOVE,
		RES_DONE
	} res_kind_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_ALLOC,
		S_SEARCH,
		S_COMPACT,
		S_FINISH,
		S_NOTFOUND
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic      in_ready;
		logic      rd_first;
		logic      rd_next;
		logic      step_prev;
		logic      found;
		logic      compact;
		logic      alloc_commit;
		logic      finish;
		logic      emit;
		res_kind_t kind;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_free;
		logic count_zero;
		logic match;
		logic more;
		logic move_needed;
		logic moved;
		logic out_free;
	} sts_t;

endpackage

[design/cba_ram.sv]
// ----------------------------------------------------------------------------
// cba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cba_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/cba_ctrl.sv]
// ----------------------------------------------------------------------------
// cba_ctrl
// Sequencer of the allocator: dispatches requests, walks the table on a free.
// ----------------------------------------------------------------------------
module cba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  cba_pkg::sts_t sts,
	output cba_pkg::cmd_t cmd
);

	cba_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cba_pkg::S_IDLE: begin
				if (s_tvalid) state_d = cba_pkg::S_DISPATCH;
			end
			cba_pkg::S_DISPATCH: begin
				if (!sts.is_free) state_d = cba_pkg::S_ALLOC;
				else if (sts.count_zero) state_d = cba_pkg::S_NOTFOUND;
				else state_d = cba_pkg::S_SEARCH;
			end
			cba_pkg::S_ALLOC: begin
				if (sts.out_free) state_d = cba_pkg::S_IDLE;
			end
			cba_pkg::S_SEARCH: begin
				if (sts.match) begin
					state_d = sts.more ? cba_pkg::S_COMPACT : cba_pkg::S_FINISH;
				end else if (!sts.more) begin
					state_d = cba_pkg::S_NOTFOUND;
				end
			end
			cba_pkg::S_COMPACT: begin
				if ((!sts.move_needed || sts.out_free) && !sts.more) begin
					state_d = cba_pkg::S_FINISH;
				end
			end
			cba_pkg::S_FINISH: begin
				if (sts.moved || sts.out_free) state_d = cba_pkg::S_IDLE;
			end
			cba_pkg::S_NOTFOUND: begin
				if (sts.out_free) state_d = cba_pkg::S_IDLE;
			end
			default: state_d = cba_pkg::S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		cmd.kind = cba_pkg::RES_DONE;
		unique case (state_q)
			cba_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			cba_pkg::S_DISPATCH: begin
				cmd.rd_first = sts.is_free && !sts.count_zero;
			end
			cba_pkg::S_ALLOC: begin
				cmd.emit         = sts.out_free;
				cmd.alloc_commit = sts.out_free;
				cmd.kind         = cba_pkg::RES_ALLOC;
			end
			cba_pkg::S_SEARCH: begin
				cmd.found     = sts.match;
				cmd.step_prev = !sts.match;
				cmd.rd_next   = sts.more;
			end
			cba_pkg::S_COMPACT: begin
				if (!sts.move_needed || sts.out_free) begin
					cmd.compact = 1'b1;
					cmd.rd_next = sts.more;
					cmd.emit    = sts.move_needed;
					cmd.kind    = cba_pkg::RES_MOVE;
				end
			end
			cba_pkg::S_FINISH: begin
				cmd.finish = sts.moved || sts.out_free;
				cmd.emit   = !sts.moved && sts.out_free;
				cmd.kind   = cba_pkg::RES_DONE;
			end
			cba_pkg::S_NOTFOUND: begin
				cmd.emit = sts.out_free;
				cmd.kind = cba_pkg::RES_NOT_FOUND;
			end
			default: cmd = '0;
		endcase
	end

	// a table walk only starts from dispatch
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cba_pkg::S_SEARCH && $past(state_q) != cba_pkg::S_SEARCH)
		|-> $past(state_q) == cba_pkg::S_DISPATCH)
		else $error("search entered from a state other than dispatch");

	// a free with no move answers exactly one done result on its finish
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && !sts.moved) |-> (cmd.emit && cmd.kind == cba_pkg::RES_DONE))
		else $error("finish without moves did not answer a result");

	// compaction never retires while a move is blocked on the output
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cba_pkg::S_COMPACT && sts.move_needed && !sts.out_free)
		|-> !cmd.compact && !cmd.rd_next)
		else $error("compaction stepped over a stalled move");

endmodule

[design/cba_datapath.sv]
// ----------------------------------------------------------------------------
// cba_datapath
// Request registers, block table, cursor and result register of the allocator.
// ----------------------------------------------------------------------------
module cba_datapath #(
	parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF,
	parameter int HEAP_BYTES = cba_pkg::HEAP_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [cba_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              s_tvalid,
	input  logic [cba_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                              s_tuser,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [cba_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast,
	input  cba_pkg::cmd_t                     cmd,
	output cba_pkg::sts_t                     sts
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int OW = cba_pkg::OFF_W;
	localparam int AW = cba_pkg::ADDR_W;
	localparam int HW = cba_pkg::HEAP_W;
	localparam logic [HW-1:0] HEAP_MAX = HW'(HEAP_BYTES);
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_BLOCKS);

	// configuration registers
	logic [AW-1:0] heap_base_q;
	logic [OW-1:0] heap_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= '0;
			heap_limit_q <= cba_pkg::HEAP_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cba_pkg::cfg_index_t'(cfg_index))
				cba_pkg::CFG_HEAP_BASE:  heap_base_q  <= cfg_data;
				cba_pkg::CFG_HEAP_LIMIT: heap_limit_q <= cfg_data[OW-1:0];
				default: ;
			endcase
		end
	end

	// request capture
	logic          func_q;
	logic [OW-1:0] size_q;
	logic [AW-1:0] addr_q;

	always_ff @(posedge clk) begin
		if (s_tvalid && cmd.in_ready) begin
			func_q <= s_tuser;
			size_q <= s_tdata[OW-1:0];
			addr_q <= s_tdata[OW+AW-1:OW];
		end
	end

	// table state
	logic [CW-1:0] count_q;
	logic [OW-1:0] last_end_q;
	logic [IW-1:0] idx_q;
	logic [OW-1:0] prev_end_q;
	logic [OW-1:0] cursor_q;
	logic          moved_q;

	// block table memory: start offset low, end offset high
	logic            ram_we;
	logic [IW-1:0]   ram_waddr;
	logic [2*OW-1:0] ram_wdata;
	logic            ram_re;
	logic [IW-1:0]   ram_raddr;
	logic [2*OW-1:0] ram_rdata;
	logic [OW-1:0]   rd_start, rd_end, rd_len;

	assign rd_start = ram_rdata[OW-1:0];
	assign rd_end   = ram_rdata[2*OW-1:OW];
	assign rd_len   = rd_end - rd_start;

	cba_ram #(
		.WIDTH(2 * OW),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// allocation checks
	logic [OW:0]   alloc_end;
	logic [HW-1:0] limit_ext, usable;
	logic          alloc_full, alloc_exhausted, alloc_ok;
	cba_pkg::status_t alloc_status;

	assign alloc_end = {1'b0, last_end_q} + {1'b0, size_q};
	assign limit_ext = HW'(heap_limit_q);
	assign usable    = (limit_ext > HEAP_MAX) ? HEAP_MAX : limit_ext;
	assign alloc_full      = (count_q == COUNT_MAX);
	assign alloc_exhausted = (HW'(alloc_end) > usable);

	always_comb begin
		priority if (size_q == '0) alloc_status = cba_pkg::ST_ZERO;
		else if (alloc_full)       alloc_status = cba_pkg::ST_FULL;
		else if (alloc_exhausted)  alloc_status = cba_pkg::ST_EXHAUSTED;
		else                       alloc_status = cba_pkg::ST_OK;
	end
	assign alloc_ok = (alloc_status == cba_pkg::ST_OK);

	// walk status
	logic [CW-1:0] idx_ext;
	logic          more;
	logic [AW-1:0] rd_addr;

	assign idx_ext = CW'(idx_q) + CW'(1);
	assign more    = (idx_ext < count_q);
	assign rd_addr = heap_base_q + AW'(rd_start);

	// memory port selection
	always_comb begin
		priority if (cmd.alloc_commit && alloc_ok) begin
			ram_we    = 1'b1;
			ram_waddr = count_q[IW-1:0];
			ram_wdata = {alloc_end[OW-1:0], last_end_q};
		end else if (cmd.compact) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q - IW'(1);
			ram_wdata = {cursor_q + rd_len, cursor_q};
		end else if (cmd.finish) begin
			ram_we    = 1'b1;
			ram_waddr = IW'(count_q - CW'(1));
			ram_wdata = '0;
		end else begin
			ram_we    = 1'b0;
			ram_waddr = '0;
			ram_wdata = '0;
		end
		ram_re    = cmd.rd_first || cmd.rd_next;
		ram_raddr = cmd.rd_first ? '0 : IW'(idx_ext);
	end

	// live count and tail end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			last_end_q <= '0;
		end else if (cmd.alloc_commit && alloc_ok) begin
			count_q    <= count_q + CW'(1);
			last_end_q <= alloc_end[OW-1:0];
		end else if (cmd.finish) begin
			count_q    <= count_q - CW'(1);
			last_end_q <= cursor_q;
		end
	end

	// walk index, previous end, cursor and move flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			prev_end_q <= '0;
			cursor_q   <= '0;
			moved_q    <= 1'b0;
		end else begin
			if (cmd.rd_first) idx_q <= '0;
			else if (cmd.rd_next) idx_q <= IW'(idx_ext);
			if (cmd.rd_first) prev_end_q <= '0;
			else if (cmd.step_prev) prev_end_q <= rd_end;
			if (cmd.found) cursor_q <= prev_end_q;
			else if (cmd.compact) cursor_q <= cursor_q + rd_len;
			if (cmd.rd_first) moved_q <= 1'b0;
			else if (cmd.compact && cmd.emit) moved_q <= 1'b1;
		end
	end

	// result register
	logic             out_valid_q;
	cba_pkg::status_t status_q;
	logic [AW-1:0]    block_address_q, move_src_q, move_dst_q;
	logic [OW-1:0]    move_length_q;
	logic             is_move_q, last_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q        <= cba_pkg::ST_OK;
			block_address_q <= '0;
			is_move_q       <= 1'b0;
			move_src_q      <= '0;
			move_dst_q      <= '0;
			move_length_q   <= '0;
			last_q          <= 1'b1;
			unique case (cmd.kind)
				cba_pkg::RES_ALLOC: begin
					status_q        <= alloc_status;
					block_address_q <= alloc_ok ? heap_base_q + AW'(last_end_q) : '0;
				end
				cba_pkg::RES_NOT_FOUND: begin
					status_q <= cba_pkg::ST_NOT_FOUND;
				end
				cba_pkg::RES_MOVE: begin
					is_move_q     <= 1'b1;
					move_src_q    <= rd_addr;
					move_dst_q    <= heap_base_q + AW'(cursor_q);
					move_length_q <= rd_len;
					last_q        <= !more;
				end
				cba_pkg::RES_DONE: ;
				default: ;
			endcase
		end
	end

	// output ports: status, block_address, move_src, move_dst, move_length
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, move_length_q, move_dst_q, move_src_q, block_address_q, status_q};
	assign m_tuser  = is_move_q;
	assign m_tlast  = last_q;

	// status to controller
	assign sts.is_free     = (func_q == cba_pkg::FUNC_FREE);
	assign sts.count_zero  = (count_q == '0);
	assign sts.match       = (rd_addr == addr_q);
	assign sts.more        = more;
	assign sts.move_needed = (rd_start != cursor_q);
	assign sts.moved       = moved_q;
	assign sts.out_free    = out_free;

	// a result is loaded only into a free output slot
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result loaded over an undelivered beat");

	// the table never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("live count beyond table depth");

	// every free that finds its block retires exactly one block
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> count_q == $past(count_q) - CW'(1))
		else $error("free did not retire one block");

endmodule

[design/compacting_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// compacting_block_allocator_core
// Top level: heap allocator with an ordered block table and free compaction.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A free walks the block table through the
// single read port of the table memory, one entry per cycle, and answers one
// move beat per block that slides left (each move stalls the walk while the
// previous beat is still waiting on the output). The table memory needs no
// clearing pass; it is usable right after reset.
module compacting_block_allocator_core #(
	parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF,
	parameter int HEAP_BYTES = cba_pkg::HEAP_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [cba_pkg::CFG_W-1:0]         cfg_data,
	// request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cba_pkg::IN_TDATA_W-1:0]    s_tdata,  // req_size, req_address
	input  logic                              s_tuser,  // func
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cba_pkg::OUT_TDATA_W-1:0]   m_tdata,  // status, block_address,
	                                                    // move_src, move_dst, move_length
	output logic                              m_tuser,  // is_move
	output logic                              m_tlast
);

	cba_pkg::cmd_t cmd;
	cba_pkg::sts_t sts;

	// sequencer
	cba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.sts     (sts),
		.cmd     (cmd)
	);

	// table and result datapath
	cba_datapath #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.HEAP_BYTES(HEAP_BYTES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.sts      (sts)
	);

	assign s_tready = cmd.in_ready;

endmodule
